### src/plo_pkg.sv
// Shared types, codes and helper functions of the price-level order book.
package plo_pkg;

  // Order operation codes.
  typedef enum logic [1:0] {
    OP_NEW    = 2'd0,
    OP_CHANGE = 2'd1,
    OP_REMOVE = 2'd2,
    OP_NONE   = 2'd3
  } op_t;

  // Side indexes of the two rings and of the level_side field.
  localparam logic SIDE_BID = 1'b0;
  localparam logic SIDE_ASK = 1'b1;

  // Sequencer states.
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SNAP_BID,
    ST_SNAP_BID_END,
    ST_SNAP_ASK,
    ST_SNAP_ASK_END,
    ST_CALC,
    ST_MOD,
    ST_PREP,
    ST_WALK
  } state_t;

  // Contents of one ring cell: one price level.
  typedef struct packed {
    logic               valid;
    logic [31:0]        price;
    logic signed [31:0] qty;
  } cell_t;

  // Signed 32-bit add that saturates at the ends of the range.
  function automatic logic signed [31:0] sat_add(input logic signed [31:0] a,
                                                 input logic signed [31:0] b);
    logic signed [32:0] s;
    s = {a[31], a} + {b[31], b};
    if (s[32] != s[31]) begin
      sat_add = s[32] ? 32'sh8000_0000 : 32'sh7fff_ffff;
    end else begin
      sat_add = s[31:0];
    end
  endfunction

endpackage

### src/plo_if.sv
// Handshake interfaces for order beats in and level beats out.
interface plo_order_if;
  logic               valid;
  logic               ready;
  logic [1:0]         operation;
  logic               side_is_bid;
  logic [31:0]        price;
  logic signed [31:0] quantity;
  logic               snapshot_request;

  modport source (output valid, operation, side_is_bid, price, quantity,
                  snapshot_request, input ready);
  modport sink   (input valid, operation, side_is_bid, price, quantity,
                  snapshot_request, output ready);
endinterface

interface plo_level_if;
  logic               valid;
  logic               ready;
  logic               level_side;
  logic [31:0]        level_price;
  logic signed [31:0] level_quantity;
  logic               side_end;
  logic               last;

  modport source (output valid, level_side, level_price, level_quantity,
                  side_end, last, input ready);
  modport sink   (input valid, level_side, level_price, level_quantity,
                  side_end, last, output ready);
endinterface

### src/plo_cell.sv
// One ring cell: holds one price level and passes it on when the ring shifts.
module plo_cell (
  input  logic          clk,
  input  logic          rst,
  input  logic          shift,
  input  plo_pkg::cell_t d,
  output plo_pkg::cell_t q
);
  import plo_pkg::*;

  logic               held_valid;
  logic [31:0]        held_price;
  logic signed [31:0] held_qty;

  // Valid flag is control state and clears on reset; the payload does not.
  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (shift) begin
      held_valid <= d.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (shift) begin
      held_price <= d.price;
      held_qty   <= d.qty;
    end
  end

  assign q = {held_valid, held_price, held_qty};
endmodule

### src/plo_rem.sv
// Remainder of a 32-bit distance by the ring length, through registered stages.
module plo_rem #(
  parameter int LEVELS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [31:0] dividend,
  output logic        done,
  output logic [$clog2(LEVELS)-1:0] rem
);
  import plo_pkg::*;

  localparam int PW = $clog2(LEVELS);
  localparam int KS = 18;
  localparam logic [4:0]    LW    = 5'(LEVELS);
  localparam logic [KS-1:0] RECIP = KS'(((1 << KS) + LEVELS - 1) / LEVELS);

  // Weight of nibble k: sixteen to the power k, reduced by the ring length.
  function automatic int nib_weight(input int k);
    int w;
    w = 1;
    for (int j = 0; j < k; j++) begin
      w = (w * 16) % LEVELS;
    end
    return w;
  endfunction

  logic [8:0]    part [8];
  logic [11:0]   fold_c;
  logic [11:0]   fold;
  logic [29:0]   prod;
  logic [11:0]   quot;
  logic [16:0]   back;
  logic          stage1;
  logic          stage2;
  logic [PW-1:0] r;

  // Each nibble times its weight keeps the remainder and shrinks the value.
  genvar gk;
  generate
    for (gk = 0; gk < 8; gk++) begin : g_nib
      localparam logic [4:0] WK = 5'(nib_weight(gk));
      assign part[gk] = {5'd0, dividend[4*gk +: 4]} * {4'd0, WK};
    end
  endgenerate

  // Folded sum, reciprocal quotient and the product to take back.
  always_comb begin
    fold_c = '0;
    for (int k = 0; k < 8; k++) begin
      fold_c = fold_c + {3'd0, part[k]};
    end
    prod = {18'd0, fold} * {12'd0, RECIP};
    back = {5'd0, quot} * {12'd0, LW};
  end

  // Stage flags: start runs through stage1 and stage2 to done, flagging rem ready.
  always_ff @(posedge clk) begin
    if (rst) begin
      stage1 <= 1'b0;
      stage2 <= 1'b0;
      done   <= 1'b0;
    end else begin
      stage1 <= start;
      stage2 <= stage1;
      done   <= stage2;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      fold <= fold_c;
    end
    if (stage1) begin
      quot <= prod[29:KS];
    end
    if (stage2) begin
      r <= PW'({5'd0, fold} - back);
    end
  end

  assign rem = r;
endmodule

### src/price_level_order_book.sv
// Two-sided price-level order book built from two rotating rings of level cells.
// Each side keeps LEVELS price levels in a ring of cells that shifts one place
// per cycle while shift is raised; all reads and writes happen at the head cell.
// An order passes the setup states ST_CALC and ST_PREP and then one full ring
// turn, which applies any window clearing, the order itself and the search
// for the next best level in a single pass; a better price that moves the
// window by LEVELS ticks or more first waits in ST_MOD for the remainder unit.
// A snapshot walks each side's ring, then sends its end beat, waiting on stalls.
// A new order is taken only when the previous one is done.
module price_level_order_book #(
  parameter int LEVELS = 16
) (
  input  logic        clk,
  input  logic        rst,
  plo_order_if.sink   order_in,
  plo_level_if.source level_out
);
  import plo_pkg::*;

  localparam int PW = $clog2(LEVELS);
  localparam logic [PW-1:0] LAST_POS = PW'(LEVELS - 1);
  localparam logic [PW:0]   LV1 = (PW+1)'(LEVELS);

  state_t state, state_next;

  // Captured order.
  op_t                r_op;
  logic               r_side;
  logic [31:0]        r_price;
  logic signed [31:0] r_qty;
  logic               r_snap;

  // Per-side best price and anchor slot.
  logic [31:0]   best [2];
  logic [PW-1:0] anchor [2];

  // Work registers of one order.
  logic [31:0]   best_new;
  logic          better;
  logic          clr_all;
  logic [PW-1:0] dm;
  logic [PW-1:0] offset;
  logic [PW-1:0] anchor_new;
  logic [PW-1:0] slot;
  logic [PW-1:0] pos;
  logic          srch;
  logic [PW:0]   bkey;
  logic [31:0]   cand_price;

  // Rings.
  cell_t ring_q [2][LEVELS];
  cell_t feedback [2];
  logic  shift;

  // Output register.
  logic               ov;
  logic               o_side;
  logic [31:0]        o_price;
  logic signed [31:0] o_qty;
  logic               o_end;
  logic               o_last;
  logic               out_free;
  logic               load;
  logic               ld_side;
  logic               ld_end;
  cell_t              ld_cell;

  // Remainder unit.
  logic          rem_start;
  logic          rem_done;
  logic [PW-1:0] rem;
  logic [31:0]   rem_in;

  // Calculation signals.
  logic [31:0] b_eff, pd, bd, dcalc;
  logic        better_c, ignore_c;
  logic [PW:0] asum;

  // Walk signals.
  cell_t       head, modc;
  logic [PW:0] kdist, key;
  logic        cleared, v, pm, nclosed, close_flag;
  logic signed [31:0] nq;

  genvar gs, gi;
  generate
    for (gs = 0; gs < 2; gs++) begin : g_side
      for (gi = 0; gi < LEVELS; gi++) begin : g_cell
        if (gi == LEVELS - 1) begin : g_tail
          plo_cell u_cell (.clk(clk), .rst(rst), .shift(shift),
                           .d(feedback[gs]), .q(ring_q[gs][gi]));
        end else begin : g_mid
          plo_cell u_cell (.clk(clk), .rst(rst), .shift(shift),
                           .d(ring_q[gs][gi+1]), .q(ring_q[gs][gi]));
        end
      end
    end
  endgenerate

  plo_rem #(.LEVELS(LEVELS)) u_rem (
    .clk(clk), .rst(rst), .start(rem_start), .dividend(rem_in),
    .done(rem_done), .rem(rem)
  );

  assign order_in.ready = (state == ST_IDLE);
  assign out_free = !ov || level_out.ready;

  // Distance and window decisions against the current best price.
  always_comb begin
    b_eff    = (best[r_side] == 32'd0) ? r_price : best[r_side];
    pd       = r_price - b_eff;
    bd       = b_eff - r_price;
    better_c = (r_side == SIDE_BID) ? (r_price > b_eff) : (r_price < b_eff);
    dcalc    = (r_price >= b_eff) ? pd : bd;
    ignore_c = !better_c && (dcalc >= 32'(LEVELS));
    rem_in   = dcalc;
    asum     = {1'b0, anchor[r_side]} + {1'b0, offset};
  end

  // Head cell of the working side after clearing and the order itself.
  always_comb begin
    head  = ring_q[r_side][0];
    kdist = (anchor[r_side] >= pos) ? {1'b0, anchor[r_side] - pos}
                                    : {1'b0, anchor[r_side]} + LV1 - {1'b0, pos};
    key   = (pos >= anchor_new) ? {1'b0, pos - anchor_new}
                                : {1'b0, pos} + LV1 - {1'b0, anchor_new};
    cleared = better && (clr_all || (kdist != '0 && kdist <= {1'b0, dm}));
    v       = head.valid && !cleared;
    pm      = (head.price == r_price);
    modc    = head;
    modc.valid = v;
    nq      = (v && pm) ? sat_add(head.qty, r_qty) : head.qty;
    nclosed = !v || (nq <= 32'sd0);
    close_flag = 1'b0;
    if (pos == slot) begin
      case (r_op)
        OP_NEW: begin
          modc.price = r_price;
          modc.qty   = v ? sat_add(head.qty, r_qty) : r_qty;
          modc.valid = 1'b1;
        end
        OP_CHANGE: begin
          modc.qty = nq;
          if (nclosed) begin
            modc.valid = 1'b0;
            close_flag = (slot == anchor_new);
          end
        end
        OP_REMOVE: begin
          if (v && pm) begin
            modc.valid = 1'b0;
          end
          close_flag = (slot == anchor_new);
        end
        default: begin
        end
      endcase
    end
  end

  // Sequencer: next state, ring shift, ring feedback and output loads.
  always_comb begin
    state_next  = state;
    shift       = 1'b0;
    feedback[0] = ring_q[0][0];
    feedback[1] = ring_q[1][0];
    load        = 1'b0;
    ld_side     = SIDE_BID;
    ld_end      = 1'b0;
    ld_cell     = ring_q[0][0];
    rem_start   = 1'b0;
    unique case (state)
      ST_IDLE: begin
        if (order_in.valid) begin
          state_next = order_in.snapshot_request ? ST_SNAP_BID : ST_CALC;
        end
      end
      ST_SNAP_BID, ST_SNAP_ASK: begin
        ld_side = (state == ST_SNAP_BID) ? SIDE_BID : SIDE_ASK;
        ld_cell = ring_q[ld_side][0];
        if (!ld_cell.valid || out_free) begin
          shift = 1'b1;
          load  = ld_cell.valid;
          if (pos == LAST_POS) begin
            state_next = (state == ST_SNAP_BID) ? ST_SNAP_BID_END : ST_SNAP_ASK_END;
          end
        end
      end
      ST_SNAP_BID_END, ST_SNAP_ASK_END: begin
        ld_side = (state == ST_SNAP_BID_END) ? SIDE_BID : SIDE_ASK;
        ld_end  = 1'b1;
        if (out_free) begin
          load       = 1'b1;
          state_next = (state == ST_SNAP_BID_END) ? ST_SNAP_ASK : ST_CALC;
        end
      end
      ST_CALC: begin
        if (r_op == OP_NONE || r_price == 32'd0 || ignore_c) begin
          state_next = ST_IDLE;
        end else if (better_c && dcalc >= 32'(LEVELS)) begin
          rem_start  = 1'b1;
          state_next = ST_MOD;
        end else begin
          state_next = ST_PREP;
        end
      end
      ST_MOD: begin
        if (rem_done) begin
          state_next = ST_PREP;
        end
      end
      ST_PREP: begin
        state_next = ST_WALK;
      end
      ST_WALK: begin
        shift = 1'b1;
        feedback[r_side] = modc;
        if (pos == LAST_POS) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Head position of the rings; a full turn brings it back to slot zero.
  always_ff @(posedge clk) begin
    if (rst) begin
      pos <= '0;
    end else if (shift) begin
      pos <= (pos == LAST_POS) ? '0 : pos + PW'(1);
    end
  end

  // Capture an order beat.
  always_ff @(posedge clk) begin
    if (order_in.valid && order_in.ready) begin
      r_op    <= op_t'(order_in.operation);
      r_side  <= order_in.side_is_bid ? SIDE_BID : SIDE_ASK;
      r_price <= order_in.price;
      r_qty   <= order_in.quantity;
      r_snap  <= order_in.snapshot_request;
    end
  end

  // Per-order work registers.
  always_ff @(posedge clk) begin
    if (state == ST_CALC) begin
      best_new <= better_c ? r_price : b_eff;
      better   <= better_c;
      clr_all  <= better_c && (dcalc >= 32'(LEVELS));
      dm       <= (better_c && dcalc < 32'(LEVELS)) ? dcalc[PW-1:0] : '0;
      offset   <= better_c ? '0 : dcalc[PW-1:0];
    end
    if (state == ST_MOD && rem_done) begin
      dm <= rem;
    end
    if (state == ST_PREP) begin
      anchor_new <= (anchor[r_side] >= dm) ? anchor[r_side] - dm
                    : PW'({1'b0, anchor[r_side]} + LV1 - {1'b0, dm});
      slot       <= better ? ((anchor[r_side] >= dm) ? anchor[r_side] - dm
                    : PW'({1'b0, anchor[r_side]} + LV1 - {1'b0, dm}))
                    : ((asum >= LV1) ? PW'(asum - LV1) : PW'(asum));
      srch       <= 1'b0;
      bkey       <= LV1;
    end
    if (state == ST_WALK) begin
      srch <= srch | close_flag;
      if (modc.valid && key < bkey) begin
        bkey       <= key;
        cand_price <= modc.price;
      end
    end
  end

  // Best price and anchor per side, settled at the end of the ring turn.
  always_ff @(posedge clk) begin
    if (rst) begin
      best[0]   <= '0;
      best[1]   <= '0;
      anchor[0] <= '0;
      anchor[1] <= '0;
    end else if (state == ST_WALK && pos == LAST_POS) begin
      if (srch || close_flag) begin
        if (modc.valid && key < bkey) begin
          best[r_side]   <= modc.price;
          anchor[r_side] <= PW'((({1'b0, anchor_new} + key) >= LV1)
                                ? ({1'b0, anchor_new} + key - LV1)
                                : ({1'b0, anchor_new} + key));
        end else if (bkey != LV1) begin
          best[r_side]   <= cand_price;
          anchor[r_side] <= PW'((({1'b0, anchor_new} + bkey) >= LV1)
                                ? ({1'b0, anchor_new} + bkey - LV1)
                                : ({1'b0, anchor_new} + bkey));
        end else begin
          best[r_side]   <= '0;
          anchor[r_side] <= anchor_new;
        end
      end else begin
        best[r_side]   <= best_new;
        anchor[r_side] <= anchor_new;
      end
    end
  end

  // Output register: one level beat held until taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      ov <= 1'b0;
    end else if (load) begin
      ov <= 1'b1;
    end else if (level_out.ready) begin
      ov <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      o_side  <= ld_side;
      o_price <= ld_end ? 32'd0 : ld_cell.price;
      o_qty   <= ld_end ? 32'sd0 : ld_cell.qty;
      o_end   <= ld_end;
      o_last  <= ld_end && (ld_side == SIDE_ASK);
    end
  end

  assign level_out.valid          = ov;
  assign level_out.level_side     = o_side;
  assign level_out.level_price    = o_price;
  assign level_out.level_quantity = o_qty;
  assign level_out.side_end       = o_end;
  assign level_out.last           = o_last;

  // The rings are aligned with slot zero at the head whenever no order is open.
  a_idle_aligned: assert property (@(posedge clk) disable iff (rst)
    (state == ST_IDLE) |-> (pos == '0))
    else $error("ring not aligned while idle");

  // An accepted order always starts work in the next cycle.
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (order_in.valid && order_in.ready) |=> (state != ST_IDLE))
    else $error("accepted order was dropped");

  // The final beat of a snapshot is always the ask-side end marker.
  a_last_marker: assert property (@(posedge clk) disable iff (rst)
    (ov && o_last) |-> (o_end && o_side == SIDE_ASK))
    else $error("last flag on a beat that is not the ask marker");

  // Snapshot walks only run for orders that asked for one.
  a_snap_req: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SNAP_BID || state == ST_SNAP_ASK) |-> r_snap)
    else $error("snapshot without request");
endmodule

### tb/sv/price_level_order_book_tb.sv
// Self-checking testbench of the price-level order book: directed and random orders.
module price_level_order_book_tb;
  import plo_pkg::*;

  localparam int LEVELS = 16;

  // One streamed level beat as the book should produce it.
  typedef struct {
    logic               side;
    logic [31:0]        price;
    logic signed [31:0] qty;
    logic               side_end;
    logic               last;
  } level_beat_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  plo_order_if ord ();
  plo_level_if lvl ();

  price_level_order_book #(.LEVELS(LEVELS)) dut (
    .clk       (clk),
    .rst       (rst),
    .order_in  (ord),
    .level_out (lvl)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Shadow copy of both rings.
  logic [31:0]        book_price [2][LEVELS];
  logic signed [31:0] book_qty   [2][LEVELS];
  logic               book_open  [2][LEVELS];
  logic [31:0]        book_best  [2];
  int                 book_anchor[2];

  level_beat_t pending_levels[$];
  int  errors = 0;
  int  orders_sent = 0;
  int  beats_checked = 0;
  int  snapshots = 0;
  bit  no_idle = 1'b0;
  int  stall_left = 0;

  task automatic report_mismatch(input string what);
    errors++;
    $display("mismatch at %0t: %s", $realtime, what);
  endtask

  function automatic logic signed [31:0] clip_sum(input logic signed [31:0] a,
                                                  input logic signed [31:0] b);
    longint total;
    total = longint'(a) + longint'(b);
    if (total > 64'sd2147483647) return 32'sh7fff_ffff;
    if (total < -64'sd2147483648) return 32'sh8000_0000;
    return total[31:0];
  endfunction

  // Walk forward from the anchor to the first open level.
  task automatic find_next_best(input int s);
    int t;
    for (int i = 0; i < LEVELS; i++) begin
      t = (book_anchor[s] + i) % LEVELS;
      if (book_open[s][t]) begin
        book_anchor[s] = t;
        book_best[s] = book_price[s][t];
        return;
      end
    end
    book_best[s] = '0;
  endtask

  // Apply one accepted order to the shadow book and queue its snapshot beats.
  task automatic apply_order(input op_t op, input logic bid, input logic [31:0] price,
                             input logic signed [31:0] qty, input logic snap);
    int          s;
    int          slot;
    logic [31:0] d;
    logic [31:0] dist_ticks;
    logic [31:0] clr;
    logic        better;
    logic        closed;
    level_beat_t b;
    s = bid ? SIDE_BID : SIDE_ASK;
    if (snap) begin
      snapshots++;
      for (int sd = 0; sd < 2; sd++) begin
        for (int i = 0; i < LEVELS; i++) begin
          if (book_open[sd][i]) begin
            b = '{sd[0], book_price[sd][i], book_qty[sd][i], 1'b0, 1'b0};
            pending_levels.push_back(b);
          end
        end
        b = '{sd[0], 32'd0, 32'sd0, 1'b1, sd == SIDE_ASK};
        pending_levels.push_back(b);
      end
    end
    if (op == OP_NONE || price == 0) return;
    if (book_best[s] == 0) book_best[s] = price;
    better = (s == SIDE_BID) ? (price > book_best[s]) : (price < book_best[s]);
    if (better) begin
      d = (s == SIDE_BID) ? price - book_best[s] : book_best[s] - price;
      clr = (d < LEVELS) ? d : LEVELS;
      for (int k = 1; k <= int'(clr); k++)
        book_open[s][(book_anchor[s] + LEVELS - k) % LEVELS] = 1'b0;
      book_anchor[s] = (book_anchor[s] + LEVELS - int'(d % LEVELS)) % LEVELS;
      book_best[s] = price;
    end
    dist_ticks = (price >= book_best[s]) ? price - book_best[s] : book_best[s] - price;
    if (dist_ticks >= LEVELS) return;
    slot = (book_anchor[s] + int'(dist_ticks)) % LEVELS;
    case (op)
      OP_NEW: begin
        book_price[s][slot] = price;
        if (book_open[s][slot]) begin
          book_qty[s][slot] = clip_sum(book_qty[s][slot], qty);
        end else begin
          book_qty[s][slot] = qty;
          book_open[s][slot] = 1'b1;
        end
      end
      OP_CHANGE: begin
        closed = 1'b1;
        if (book_open[s][slot]) begin
          if (book_price[s][slot] == price)
            book_qty[s][slot] = clip_sum(book_qty[s][slot], qty);
          closed = (book_qty[s][slot] <= 0);
        end
        if (closed) begin
          book_open[s][slot] = 1'b0;
          if (slot == book_anchor[s]) find_next_best(s);
        end
      end
      default: begin
        if (book_open[s][slot] && book_price[s][slot] == price)
          book_open[s][slot] = 1'b0;
        if (slot == book_anchor[s]) find_next_best(s);
      end
    endcase
  endtask

  // Send one order beat after a random gap and wait for its acceptance.
  task automatic send_order(input op_t op, input logic bid, input logic [31:0] price,
                            input logic signed [31:0] qty, input logic snap);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 7);
    if (gap > 0) begin
      ord.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    ord.valid            <= 1'b1;
    ord.operation        <= op;
    ord.side_is_bid      <= bid;
    ord.price            <= price;
    ord.quantity         <= qty;
    ord.snapshot_request <= snap;
    do @(posedge clk); while (!ord.ready);
    apply_order(op, bid, price, qty, snap);
    orders_sent++;
  endtask

  task automatic idle_line();
    ord.valid <= 1'b0;
    @(posedge clk);
  endtask

  // Check each level beat against the oldest expectation; draw the next stall.
  always @(posedge clk) begin
    level_beat_t e;
    if (!rst && lvl.valid && lvl.ready) begin
      beats_checked++;
      if (pending_levels.size() == 0) begin
        report_mismatch($sformatf("unexpected level beat price %0d", lvl.level_price));
      end else begin
        e = pending_levels.pop_front();
        if (lvl.level_side !== e.side)
          report_mismatch($sformatf("level_side %b, want %b", lvl.level_side, e.side));
        if (lvl.level_price !== e.price)
          report_mismatch($sformatf("level_price %0d, want %0d", lvl.level_price, e.price));
        if (lvl.level_quantity !== e.qty)
          report_mismatch($sformatf("level_quantity %0d, want %0d",
                                    lvl.level_quantity, e.qty));
        if (lvl.side_end !== e.side_end)
          report_mismatch($sformatf("side_end %b, want %b", lvl.side_end, e.side_end));
        if (lvl.last !== e.last)
          report_mismatch($sformatf("last %b, want %b", lvl.last, e.last));
      end
      stall_left = no_idle ? 0 : $urandom_range(0, 7);
    end else if (stall_left > 0) begin
      stall_left--;
    end
    lvl.ready <= (stall_left == 0);
  end

  // Directed orders: empty sides, window moves, saturation and odd cases.
  task automatic test_directed();
    send_order(OP_NEW, 1'b1, 32'd0, 32'sd5, 1'b1);               // price zero, empty book
    send_order(OP_NEW, 1'b1, 32'd900, 32'sd10, 1'b0);            // empty bid side opens
    send_order(OP_NEW, 1'b1, 32'd895, 32'sd3, 1'b0);
    send_order(OP_NEW, 1'b1, 32'd905, 32'sd5, 1'b1);             // better bid clears five
    send_order(OP_NEW, 1'b1, 32'd902, 32'sh7fff_ffff, 1'b0);
    send_order(OP_NEW, 1'b1, 32'd902, 32'sd100, 1'b1);           // saturates high
    send_order(OP_CHANGE, 1'b1, 32'd903, -32'sd5, 1'b0);         // change on a closed level
    send_order(OP_CHANGE, 1'b1, 32'd902, 32'sh8000_0000, 1'b1);  // falls to -1 and closes
    send_order(OP_NEW, 1'b0, 32'd1000, 32'sh8000_0000, 1'b0);
    send_order(OP_NEW, 1'b0, 32'd1000, -32'sd5, 1'b0);           // saturates low
    send_order(OP_NEW, 1'b0, 32'd1016, 32'sd7, 1'b0);            // outside the window
    send_order(OP_NEW, 1'b0, 32'd1015, 32'sd8, 1'b1);
    send_order(OP_REMOVE, 1'b0, 32'd1003, 32'sd0, 1'b0);         // remove of a closed level
    send_order(OP_REMOVE, 1'b0, 32'd1000, 32'sd0, 1'b1);         // anchor removed, search on
    send_order(OP_NONE, 1'b0, 32'd1, 32'sd9, 1'b1);              // unused code ignored
    send_order(OP_NEW, 1'b1, 32'd921, 32'sd4, 1'b1);             // jump of a full window
    send_order(OP_NEW, 1'b1, 32'hffff_ffff, -32'sd1, 1'b0);
    send_order(OP_NEW, 1'b0, 32'd1, 32'sd1, 1'b0);
    send_order(OP_NEW, 1'b0, 32'hffff_ffff, 32'sd2, 1'b1);
    send_order(OP_CHANGE, 1'b1, 32'hffff_ffff, 32'sd1, 1'b0);    // size -1 plus 1 closes
    send_order(OP_REMOVE, 1'b1, 32'hffff_fff0, 32'sd0, 1'b1);
    send_order(OP_CHANGE, 1'b0, 32'd1, -32'sd1, 1'b1);           // ask side empties
    idle_line();
  endtask

  // Price near the current best of a side, mostly inside the window.
  function automatic logic [31:0] price_near(input logic bid);
    int          s;
    logic [31:0] ref_p;
    int          off;
    s = bid ? SIDE_BID : SIDE_ASK;
    ref_p = (book_best[s] != 0) ? book_best[s] : (bid ? 32'd50_000 : 32'd50_010);
    off = $urandom_range(0, 17) - (($urandom_range(0, 7) == 0) ? $urandom_range(1, 4) : 0);
    return bid ? ref_p - off : ref_p + off;
  endfunction

  // Random orders: well-formed book traffic with a share of noise.
  task automatic test_random_book(input int count);
    op_t                op;
    logic               bid;
    logic [31:0]        price;
    logic signed [31:0] qty;
    int                 pick;
    for (int n = 0; n < count; n++) begin
      bid = $urandom_range(0, 1);
      pick = $urandom_range(0, 99);
      op = (pick < 45) ? OP_NEW : (pick < 75) ? OP_CHANGE : (pick < 97) ? OP_REMOVE : OP_NONE;
      pick = $urandom_range(0, 99);
      if (pick < 85) price = price_near(bid);
      else if (pick < 92) price = price_near(bid) + ($urandom_range(0, 1) ? 40 : -40);
      else if (pick < 98) price = $urandom;
      else price = '0;
      pick = $urandom_range(0, 99);
      if (pick < 70) qty = $urandom_range(1, 500);
      else if (pick < 85) qty = -$urandom_range(0, 600);
      else if (pick < 92) qty = $urandom;
      else qty = $urandom_range(0, 1) ? 32'sh7fff_ffff : 32'sh8000_0000;
      send_order(op, bid, price, qty, $urandom_range(0, 5) == 0);
    end
    idle_line();
  endtask

  initial begin
    ord.valid = 1'b0;
    ord.operation = OP_NONE;
    ord.side_is_bid = 1'b0;
    ord.price = '0;
    ord.quantity = '0;
    ord.snapshot_request = 1'b0;
    for (int sd = 0; sd < 2; sd++) begin
      book_best[sd] = '0;
      book_anchor[sd] = 0;
      for (int i = 0; i < LEVELS; i++) begin
        book_open[sd][i] = 1'b0;
        book_price[sd][i] = '0;
        book_qty[sd][i] = '0;
      end
    end
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_directed();
    test_random_book(280);
    no_idle = 1'b1;
    test_random_book(70);
    no_idle = 1'b0;
    send_order(OP_NONE, 1'b1, 32'd0, 32'sd0, 1'b1);
    idle_line();

    while (pending_levels.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    $display("Covered %0d orders and %0d snapshots; %0d level beats checked.",
             orders_sent, snapshots, beats_checked);
    if (errors == 0 && pending_levels.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // Watchdog on the whole run.
  initial begin
    #20_000_000;
    $display("Run timed out with %0d level beats still expected.", pending_levels.size());
    $display("simulation failed");
    $finish;
  end

endmodule
